[rtl/core/rqsi_pkg.sv]
package rqsi_pkg;

  // Default queue depth
  localparam int QUEUE_DEPTH_DEF = 16;

  // Scheduling modes
  localparam logic [1:0] MODE_FIFO  = 2'd0;
  localparam logic [1:0] MODE_PRIO  = 2'd1;
  localparam logic [1:0] MODE_SHORT = 2'd2;

  // Input beat kinds
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_POP    = 1'b1;

  // One queue entry
  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] est;
  } entry_t;

  // Entry travelling down the chain during an insert
  typedef struct packed {
    logic   valid;
    logic   placed;   // new entry already sits upstream, this is a displaced one
    entry_t ent;
  } carry_t;

  // Control broadcast to every cell
  typedef struct packed {
    logic       pop;
    logic [1:0] mode;
  } cell_ctrl_t;

  // True when the held entry must go behind the new one
  function automatic logic key_gt(logic [1:0] mode, entry_t held, entry_t nw);
    logic r;
    r = 1'b0;
    case (mode)
      MODE_PRIO:  r = (held.prio > nw.prio);
      MODE_SHORT: r = (held.est > nw.est);
      default:    r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/ready_queue_sorted_insert_unit.sv]
// Sorted ready queue for a short-term scheduler.
// Input channel (in_valid / in_stall): one beat is an insert (in_kind 0) carrying
// in_proc_id, in_prio_level and in_burst_estimate, or a pop (in_kind 1).
// Result channel (out_valid / out_stall): exactly one beat per input beat, in order.
// A pop returns the head id with out_head_valid set, or out_error_flag on an empty
// queue. An insert returns all zeros, or out_error_flag when the queue is full.
// The result is registered and appears in the cycle after the input beat is taken.
// Queue order follows the mode written via cfg_wr_data: tail append (0 or 3),
// lowest priority first (1) or shortest estimate first (2); ties keep arrival order.
// A pop, a rejected insert and a pop of an empty queue finish without a walk.
// An accepted insert walks a carry down the cell chain, one cell per cycle, and
// stops at the first free cell: the unit is busy until the carry reaches the cell
// at the fill count (entries before the insert) and takes no new beat meanwhile.
// Reset empties the queue and selects mode 0; no clearing pass is needed.
// While out_stall is high with a result pending, the result holds and no new beat
// is taken.
module ready_queue_sorted_insert_unit
  import rqsi_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [15:0] in_proc_id,
  input  logic [7:0]  in_prio_level,
  input  logic [15:0] in_burst_estimate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_head_id,
  output logic        out_head_valid,
  output logic        out_error_flag
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_INSERT = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [SW-1:0] step_r, step_nxt;
  logic [1:0]  mode_r;
  carry_t      inj_r, inj_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_id_r, out_id_nxt;
  logic        out_hv_r, out_hv_nxt;
  logic        out_err_r, out_err_nxt;

  logic        accept, is_pop, empty, full, do_pop, do_ins, ins_done;
  cell_ctrl_t  ctrl;
  carry_t      carry [QUEUE_DEPTH+1];
  entry_t      hold  [QUEUE_DEPTH];
  entry_t      nbr   [QUEUE_DEPTH];
  logic        occ   [QUEUE_DEPTH];

  // Handshake and decode
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign is_pop   = (in_kind == KIND_POP);
  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign do_pop   = accept && is_pop && !empty;
  assign do_ins   = accept && !is_pop && !full;
  assign ins_done = (state_r == ST_INSERT) && (CW'(step_r) == count_r);

  assign ctrl.pop  = do_pop;
  assign ctrl.mode = mode_r;

  // Mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FIFO;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // Sequencer: fill count, insert step and injected carry
  always_comb begin
    state_nxt        = state_r;
    count_nxt        = count_r;
    step_nxt         = step_r;
    inj_nxt          = inj_r;
    inj_nxt.valid    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (do_pop) begin
          count_nxt = count_r - 1'b1;
        end else if (do_ins) begin
          state_nxt      = ST_INSERT;
          step_nxt       = '0;
          inj_nxt.valid  = 1'b1;
          inj_nxt.placed = 1'b0;
          inj_nxt.ent.id   = in_proc_id;
          inj_nxt.ent.prio = in_prio_level;
          inj_nxt.ent.est  = in_burst_estimate;
        end
      end
      ST_INSERT: begin
        if (ins_done) begin
          state_nxt = ST_IDLE;
          count_nxt = count_r + 1'b1;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      step_r  <= '0;
      inj_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      step_r  <= step_nxt;
      inj_r   <= inj_nxt;
    end
  end

  // Result register
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_id_nxt    = out_id_r;
    out_hv_nxt    = out_hv_r;
    out_err_nxt   = out_err_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_id_nxt    = do_pop ? hold[0].id : 16'd0;
      out_hv_nxt    = do_pop;
      out_err_nxt   = is_pop ? empty : full;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_id_r  <= out_id_nxt;
    out_hv_r  <= out_hv_nxt;
    out_err_r <= out_err_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_head_id    = out_id_r;
  assign out_head_valid = out_hv_r;
  assign out_error_flag = out_err_r;

  // Cell chain
  assign carry[0] = inj_r;

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    assign occ[gi] = (CW'(gi) < count_r);
    if (gi == QUEUE_DEPTH - 1) begin : g_last
      assign nbr[gi] = '0;
    end else begin : g_mid
      assign nbr[gi] = hold[gi+1];
    end
    rqsi_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .occupied  (occ[gi]),
      .carry_in  (carry[gi]),
      .nbr_entry (nbr[gi]),
      .carry_out (carry[gi+1]),
      .hold_out  (hold[gi])
    );
  end

  // Checks
  a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
    !carry[QUEUE_DEPTH].valid)
    else $error("insert carry ran off the end of the chain");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("fill count beyond queue depth");

  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INSERT) |-> in_stall)
    else $error("beat taken during an insert walk");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_pop |=> (count_r == $past(count_r) - 1'b1) && (state_r == ST_IDLE))
    else $error("pop did not drop the fill count");

  a_ins_done: assert property (@(posedge clk) disable iff (!rst_n)
    ins_done |=> (state_r == ST_IDLE) && (count_r == $past(count_r) + 1'b1))
    else $error("insert walk did not finish cleanly");

endmodule

[rtl/core/rqsi_cell.sv]
module rqsi_cell
  import rqsi_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  logic       occupied,
  input  carry_t     carry_in,
  input  entry_t     nbr_entry,
  output carry_t     carry_out,
  output entry_t     hold_out
);

  entry_t hold_r, hold_nxt;
  carry_t carry_r, carry_nxt;

  // Pop shifts toward the head; an insert carry is absorbed, swapped or passed on
  always_comb begin
    hold_nxt        = hold_r;
    carry_nxt       = carry_in;
    carry_nxt.valid = 1'b0;
    if (ctrl.pop) begin
      hold_nxt = nbr_entry;
    end else if (carry_in.valid) begin
      if (!occupied) begin
        hold_nxt = carry_in.ent;
      end else if (carry_in.placed || key_gt(ctrl.mode, hold_r, carry_in.ent)) begin
        hold_nxt         = carry_in.ent;
        carry_nxt.valid  = 1'b1;
        carry_nxt.placed = 1'b1;
        carry_nxt.ent    = hold_r;
      end else begin
        carry_nxt = carry_in;
      end
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

  // Carry stage toward the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carry_r <= '0;
    end else begin
      carry_r <= carry_nxt;
    end
  end

  assign carry_out = carry_r;
  assign hold_out  = hold_r;

endmodule

[test/ready_queue_sorted_insert_unit_tb.sv]
`timescale 1ns / 1ps

module ready_queue_sorted_insert_unit_tb
  import rqsi_pkg::*;
();

  localparam int DEPTH = QUEUE_DEPTH_DEF;
  // Unused mode code, treated as fifo
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_BEATS = 135;
  // Long enough for the longest insert walk
  localparam int SETTLE_CYCLES = DEPTH + 4;
  localparam int HOLD_CYCLES = 150;

  typedef struct packed {
    logic        kind;
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] est;
  } req_beat_t;

  typedef struct packed {
    logic [15:0] head_id;
    logic        head_valid;
    logic        error_flag;
  } head_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_wr_data = MODE_FIFO;
  logic        in_valid = 1'b0;
  logic        in_kind = KIND_INSERT;
  logic [15:0] in_proc_id = '0;
  logic [7:0]  in_prio_level = '0;
  logic [15:0] in_burst_estimate = '0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] out_head_id;
  logic        out_head_valid;
  logic        out_error_flag;

  ready_queue_sorted_insert_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_proc_id       (in_proc_id),
    .in_prio_level    (in_prio_level),
    .in_burst_estimate(in_burst_estimate),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_head_id      (out_head_id),
    .out_head_valid   (out_head_valid),
    .out_error_flag   (out_error_flag)
  );

  always #5 clk = ~clk;

  // Mirror of the ready queue, head at index 0
  entry_t     rq_entries [DEPTH];
  int         rq_fill = 0;
  logic [1:0] rq_mode = MODE_FIFO;

  req_beat_t  send_q[$];
  head_rsp_t  head_expect_q[$];
  int         err_count = 0;
  int         pushed_cnt = 0;
  int         taken_cnt = 0;
  int         cyc = 0;
  int         gen_fill = 0;
  bit         in_fire = 1'b0;
  int         hold_left = 0;
  int         hold_mark = 300;
  bit         quiet;

  // No random idling on either side in this window; the long hold-off still applies
  assign quiet = (cyc >= 2000) && (cyc < 5000);

  function automatic logic [15:0] order_key(logic [1:0] mode, logic [7:0] p, logic [15:0] e);
    return (mode == MODE_PRIO) ? {8'd0, p} : e;
  endfunction

  // Apply one beat to the mirror and return the head result it yields
  function automatic head_rsp_t ready_queue_step(req_beat_t b);
    head_rsp_t   r;
    int          pos;
    logic [15:0] nk;
    r = '0;
    if (b.kind == KIND_POP) begin
      if (rq_fill == 0) begin
        r.error_flag = 1'b1;
      end else begin
        r.head_id = rq_entries[0].id;
        r.head_valid = 1'b1;
        for (int i = 1; i < rq_fill; i++) rq_entries[i-1] = rq_entries[i];
        rq_fill--;
      end
    end else if (rq_fill >= DEPTH) begin
      r.error_flag = 1'b1;
    end else begin
      pos = rq_fill;
      // sorted modes: go in front of the first strictly greater key
      if (rq_mode == MODE_PRIO || rq_mode == MODE_SHORT) begin
        nk = order_key(rq_mode, b.prio, b.est);
        for (int i = 0; i < rq_fill; i++) begin
          if (pos == rq_fill &&
              order_key(rq_mode, rq_entries[i].prio, rq_entries[i].est) > nk) pos = i;
        end
      end
      for (int i = rq_fill; i > pos; i--) rq_entries[i] = rq_entries[i-1];
      rq_entries[pos].id = b.id;
      rq_entries[pos].prio = b.prio;
      rq_entries[pos].est = b.est;
      rq_fill++;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    err_count++;
    $display("MISMATCH at %0t: %s got %h want %h", $time, what, got, want);
  endtask

  // Monitor: check result beats, predict accepted input beats
  always @(posedge clk) begin : mon
    head_rsp_t want;
    if (rst_n) begin
      cyc++;
      if (out_valid && !out_stall) begin
        if (head_expect_q.size() == 0) begin
          flag_mismatch("result beat with none pending", out_head_id, '0);
        end else begin
          want = head_expect_q.pop_front();
          if (out_head_id !== want.head_id)
            flag_mismatch("head_id", out_head_id, want.head_id);
          if (out_head_valid !== want.head_valid)
            flag_mismatch("head_valid", out_head_valid, want.head_valid);
          if (out_error_flag !== want.error_flag)
            flag_mismatch("error_flag", out_error_flag, want.error_flag);
        end
      end
      if (in_valid && !in_stall) begin
        head_expect_q.push_back(ready_queue_step('{kind: in_kind, id: in_proc_id,
                                                   prio: in_prio_level,
                                                   est: in_burst_estimate}));
        taken_cnt++;
        in_fire = 1'b1;
      end else begin
        in_fire = 1'b0;
      end
      if (cfg_wr_en) rq_mode = cfg_wr_data;
    end
  end

  // Driver: offer the next pending beat once the current one is taken
  always @(negedge clk) begin : drv
    req_beat_t nb;
    if (rst_n && (!in_valid || in_fire)) begin
      if (send_q.size() > 0 && (quiet || $urandom_range(99) >= 16)) begin
        nb = send_q.pop_front();
        in_valid <= 1'b1;
        in_kind <= nb.kind;
        in_proc_id <= nb.id;
        in_prio_level <= nb.prio;
        in_burst_estimate <= nb.est;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, plus a long hold-off now and then
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (taken_cnt >= hold_mark) begin
        hold_mark += 600;
        hold_left = HOLD_CYCLES;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 16);
      end
    end
  end

  task automatic queue_insert(logic [15:0] id, logic [7:0] p, logic [15:0] e);
    send_q.push_back('{kind: KIND_INSERT, id: id, prio: p, est: e});
    pushed_cnt++;
    if (gen_fill < DEPTH) gen_fill++;
  endtask

  // Pop fields are ignored by the block but still randomized
  task automatic queue_take_head();
    send_q.push_back('{kind: KIND_POP, id: 16'($urandom), prio: 8'($urandom),
                       est: 16'($urandom)});
    pushed_cnt++;
    if (gen_fill > 0) gen_fill--;
  endtask

  // Keys: ties, extremes or full range
  task automatic rand_insert();
    logic [7:0]  p;
    logic [15:0] e;
    case ($urandom_range(3))
      0: begin
        p = 8'($urandom_range(3));
        e = 16'($urandom_range(3));
      end
      1: begin
        p = $urandom_range(1) ? 8'hff : 8'h00;
        e = $urandom_range(1) ? 16'hffff : 16'h0000;
      end
      default: begin
        p = 8'($urandom);
        e = 16'($urandom);
      end
    endcase
    queue_insert(16'($urandom), p, e);
  endtask

  // Wait until every beat is taken and answered, then let the block settle
  task automatic wait_drain();
    while (taken_cnt != pushed_cnt || head_expect_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(logic [1:0] m);
    wait_drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stim
    logic [1:0] mode_seq [RAND_PHASES];
    int         phase_start;
    int         cnt;
    mode_seq = '{MODE_PRIO, MODE_SHORT, MODE_FIFO, MODE_SPARE, MODE_SHORT,
                 MODE_PRIO, MODE_FIFO, MODE_SHORT, MODE_PRIO, MODE_PRIO};
    mode_seq[RAND_PHASES-1] = 2'($urandom_range(3));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // fifo after reset: empty pop, field extremes
    queue_take_head();
    queue_insert(16'hffff, 8'hff, 16'hffff);
    queue_insert(16'h0000, 8'h00, 16'h0000);
    queue_take_head();
    queue_take_head();
    queue_take_head();

    // priority order with ties kept in arrival order
    set_mode(MODE_PRIO);
    queue_insert(16'h0a01, 8'd200, 16'h0005);
    queue_insert(16'h0a02, 8'd0, 16'h0004);
    queue_insert(16'h0a03, 8'd200, 16'h0003);
    queue_insert(16'h0a04, 8'd255, 16'h0002);
    queue_insert(16'h0a05, 8'd0, 16'h0001);
    repeat (5) queue_take_head();

    // shortest estimate; leave two entries behind
    set_mode(MODE_SHORT);
    queue_insert(16'hb001, 8'd9, 16'hffff);
    queue_insert(16'hb002, 8'd9, 16'h0000);
    queue_insert(16'hb003, 8'd9, 16'hffff);
    queue_insert(16'hb004, 8'd9, 16'h0007);
    queue_take_head();
    queue_take_head();

    // unused mode on a non-empty queue appends at the tail
    set_mode(MODE_SPARE);
    queue_insert(16'hc001, 8'h00, 16'h0000);
    repeat (3) queue_take_head();

    // random phases, mode changed with whatever the queue holds
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      set_mode(mode_seq[ph]);
      phase_start = pushed_cnt;
      while (pushed_cnt - phase_start < PHASE_BEATS) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            // fill past full, then drain past empty
            cnt = DEPTH - gen_fill + $urandom_range(2, 1);
            repeat (cnt) rand_insert();
            cnt = gen_fill + 1;
            repeat (cnt) queue_take_head();
          end
          4, 5, 6, 7: begin
            cnt = $urandom_range(20, 8);
            repeat (cnt) begin
              if ($urandom_range(99) < ((gen_fill < 4) ? 75 : 50)) rand_insert();
              else queue_take_head();
            end
          end
          default: begin
            cnt = $urandom_range(8, 2);
            repeat (cnt) begin
              if ($urandom_range(1))
                queue_insert(16'($urandom), 8'($urandom), 16'($urandom));
              else queue_take_head();
            end
          end
        endcase
      end
    end

    wait_drain();
    if (err_count == 0 && head_expect_q.size() == 0) begin
      $display("ready_queue_sorted_insert_unit_tb passed");
    end else begin
      $display("ready_queue_sorted_insert_unit_tb failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("ready_queue_sorted_insert_unit_tb failed");
    $finish;
  end

endmodule
